FILE: rtl/gpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg: shared types and constants of the GF(2^8) parity encoder
// Field constants, the alpha power table, configuration register indexes and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam logic [8:0] GF_POLY  = 9'h11D;
    localparam logic [8:0] GF_ORDER = 9'd255;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 1'b1;
    localparam int CFG_DATA_W = 6;

    typedef logic [255:0][7:0] gf_table_t;

    // Builds alpha^k for k = 0..255 at elaboration time.
    function automatic gf_table_t gf_build_exp();
        gf_table_t  t;
        logic [8:0] x;
        x = 9'd1;
        for (int k = 0; k < 256; k++) begin
            t[k] = x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ GF_POLY;
            end
        end
        return t;
    endfunction

    localparam gf_table_t GF_EXP = gf_build_exp();

    // Shift-and-add product in GF(2^8).
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'd0;
        p = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                r = r ^ p;
            end
            p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY[7:0] : 8'h00);
        end
        return r;
    endfunction

    typedef struct packed {
        logic       load;       // capture the input item and its coefficients
        logic       mac;        // fold the held item into the accumulators
        logic       snap;       // move the column result to the output bank
        logic       out_load;   // load the next parity byte into the output register
        logic       out_last;
        logic [2:0] out_index;
    } gpe_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_final;
        logic out_valid;
    } gpe_status_t;

endpackage

FILE: rtl/gf256_parity_encoder.sv
`timescale 1ns / 1ps
// Flow: a data item is captured with its coefficient lookup, then folded into all parity lanes
// in the MAC state, where s_tready is low; an item out of range is dropped there instead.
// No new item is taken until MAC is left. A column's parity bytes leave one per cycle while
// m_tready allows, via the output bank and the output register, overlapping the next column.
// A final item waits only if the previous column's parity bytes are still draining.
// Reset: synchronous, active low; clears accumulators and counters and sets config to 1.
// ----------------------------------------------------------------------------
// gf256_parity_encoder: erasure-code parity generator over GF(2^8)
// Accumulates data bytes column by column into parity lanes and emits the
// parity bytes of each column on the master stream.
// ----------------------------------------------------------------------------
module gf256_parity_encoder #(
    parameter int MAX_DATA   = 32,
    parameter int MAX_PARITY = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // data_byte, packet_index, zero pad
    input  logic [1:0]                      s_tuser,   // is_padding, last_column
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // parity_byte, parity_index, zero pad
    output logic                            m_tlast,   // last_of_column
    output logic [0:0]                      m_tuser    // end_of_block
);

    logic [5:0]           data_count_reg;
    logic [3:0]           parity_count_reg;
    gpe_pkg::gpe_cmd_t    cmd;
    gpe_pkg::gpe_status_t status;
    logic [7:0]           parity_byte;
    logic [2:0]           parity_index;
    logic                 end_of_block;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_count_reg   <= 6'd1;
            parity_count_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                gpe_pkg::CFG_DATA_COUNT:   data_count_reg   <= cfg_wr_data;
                gpe_pkg::CFG_PARITY_COUNT: parity_count_reg <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    gpe_ctrl #(
        .MAX_PARITY (MAX_PARITY)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .parity_count (parity_count_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tready     (m_tready),
        .status       (status),
        .cmd          (cmd)
    );

    gpe_datapath #(
        .MAX_DATA   (MAX_DATA),
        .MAX_PARITY (MAX_PARITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .data_count       (data_count_reg),
        .s_data_byte      (s_tdata[7:0]),
        .s_packet_index   (s_tdata[12:8]),
        .s_is_padding     (s_tuser[0]),
        .s_last_column    (s_tuser[1]),
        .m_tready         (m_tready),
        .cmd              (cmd),
        .status           (status),
        .m_tvalid         (m_tvalid),
        .m_parity_byte    (parity_byte),
        .m_parity_index   (parity_index),
        .m_last_of_column (m_tlast),
        .m_end_of_block   (end_of_block)
    );

    assign m_tdata    = {5'd0, parity_index, parity_byte};
    assign m_tuser[0] = end_of_block;

endmodule

FILE: rtl/gpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_ctrl: controller of the GF(2^8) parity encoder
// Sequences item capture and accumulation, and runs the parity emission
// counter that drains the output bank one byte at a time.
// ----------------------------------------------------------------------------
module gpe_ctrl #(
    parameter int MAX_PARITY = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [3:0]           parity_count,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 m_tready,
    input  gpe_pkg::gpe_status_t status,
    output gpe_pkg::gpe_cmd_t    cmd
);

    localparam int IW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_MAC  = 1'b1;

    logic          state_reg, state_next;
    logic          emit_busy_reg, emit_busy_next;
    logic [IW-1:0] emit_cnt_reg, emit_cnt_next;
    logic [7:0]    m_sat;
    logic [7:0]    m_last;
    logic          out_load;
    logic          out_last;

    always_comb begin
        if (parity_count == 4'd0) begin
            m_sat = 8'd1;
        end else if (8'(parity_count) > 8'(MAX_PARITY)) begin
            m_sat = 8'(MAX_PARITY);
        end else begin
            m_sat = 8'(parity_count);
        end
    end

    assign m_last   = m_sat - 8'd1;
    assign s_tready = (state_reg == STATE_IDLE);
    assign out_load = emit_busy_reg && (!status.out_valid || m_tready);
    assign out_last = (8'(emit_cnt_reg) == m_last);

    always_comb begin
        cmd            = '0;
        cmd.out_load   = out_load;
        cmd.out_last   = out_last;
        cmd.out_index  = 3'(emit_cnt_reg);
        state_next     = state_reg;
        emit_busy_next = emit_busy_reg;
        emit_cnt_next  = emit_cnt_reg;

        if (out_load) begin
            if (out_last) begin
                emit_busy_next = 1'b0;
            end else begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            STATE_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = STATE_MAC;
                end
            end
            STATE_MAC: begin
                if (!status.in_range) begin
                    state_next = STATE_IDLE;
                end else if (status.is_final) begin
                    // The output bank must be drained before a new column lands in it.
                    if (!emit_busy_reg) begin
                        cmd.mac        = 1'b1;
                        cmd.snap       = 1'b1;
                        emit_busy_next = 1'b1;
                        emit_cnt_next  = '0;
                        state_next     = STATE_IDLE;
                    end
                end else begin
                    cmd.mac    = 1'b1;
                    state_next = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_IDLE;
            emit_busy_reg <= 1'b0;
            emit_cnt_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            emit_busy_reg <= emit_busy_next;
            emit_cnt_reg  <= emit_cnt_next;
        end
    end

    a_snap_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.snap |-> !emit_busy_reg && !out_load)
        else $error("column result moved while the output bank was still draining");

    a_emit_starts_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.snap |=> emit_busy_reg && (emit_cnt_reg == '0))
        else $error("emission did not start at parity byte zero");

    a_load_then_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == STATE_MAC && !s_tready)
        else $error("captured item was not followed by an accumulation cycle");

    a_emit_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy_reg |-> 8'(emit_cnt_reg) <= m_last)
        else $error("emission counter ran past the parity count");

endmodule

FILE: rtl/gpe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_datapath: datapath of the GF(2^8) parity encoder
// Per-lane coefficient lookup, GF multiply-accumulate, the output bank that
// holds a finished column, and the result output register.
// ----------------------------------------------------------------------------
module gpe_datapath #(
    parameter int MAX_DATA   = 32,
    parameter int MAX_PARITY = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [5:0]           data_count,
    input  logic [7:0]           s_data_byte,
    input  logic [4:0]           s_packet_index,
    input  logic                 s_is_padding,
    input  logic                 s_last_column,
    input  logic                 m_tready,
    input  gpe_pkg::gpe_cmd_t    cmd,
    output gpe_pkg::gpe_status_t status,
    output logic                 m_tvalid,
    output logic [7:0]           m_parity_byte,
    output logic [2:0]           m_parity_index,
    output logic                 m_last_of_column,
    output logic                 m_end_of_block
);

    // (i * j) mod 255 for a product below 4096: fold the high nibble onto the low byte.
    function automatic logic [7:0] mod_order(input logic [11:0] x);
        logic [8:0] s;
        s = 9'(x[7:0]) + 9'(x[11:8]);
        if (s >= gpe_pkg::GF_ORDER) begin
            s = s - gpe_pkg::GF_ORDER;
        end
        return s[7:0];
    endfunction

    logic [7:0] byte_reg;
    logic [4:0] index_reg;
    logic       last_col_reg;
    logic [7:0] coef_reg   [MAX_PARITY];
    logic [7:0] coef_next  [MAX_PARITY];
    logic [7:0] prod       [MAX_PARITY];
    logic [7:0] acc_reg    [MAX_PARITY];
    logic [7:0] shadow_reg [MAX_PARITY];
    logic       eob_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_index_reg;
    logic       out_last_reg;
    logic       out_eob_reg;
    logic [8:0] n_sat;

    always_comb begin
        if (data_count == 6'd0) begin
            n_sat = 9'd1;
        end else if (9'(data_count) > 9'(MAX_DATA)) begin
            n_sat = 9'(MAX_DATA);
        end else begin
            n_sat = 9'(data_count);
        end
    end

    assign status.in_range  = (9'(index_reg) < n_sat);
    assign status.is_final  = (9'(index_reg) == (n_sat - 9'd1));
    assign status.out_valid = out_valid_reg;

    for (genvar lane = 0; lane < MAX_PARITY; lane++) begin : g_lane
        logic [11:0] ij;
        assign ij              = 12'(lane) * 12'(s_packet_index);
        assign coef_next[lane] = gpe_pkg::GF_EXP[mod_order(ij)];
        assign prod[lane]      = gpe_pkg::gf_mul(coef_reg[lane], byte_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg     <= s_is_padding ? 8'd0 : s_data_byte;
            index_reg    <= s_packet_index;
            last_col_reg <= s_last_column;
            for (int i = 0; i < MAX_PARITY; i++) begin
                coef_reg[i] <= coef_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PARITY; i++) begin
                acc_reg[i] <= 8'd0;
            end
        end else if (cmd.mac) begin
            for (int i = 0; i < MAX_PARITY; i++) begin
                acc_reg[i] <= cmd.snap ? 8'd0 : (acc_reg[i] ^ prod[i]);
            end
        end
    end

    // The output bank shifts toward entry zero as parity bytes leave.
    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            eob_reg <= last_col_reg;
            for (int i = 0; i < MAX_PARITY; i++) begin
                shadow_reg[i] <= acc_reg[i] ^ prod[i];
            end
        end else if (cmd.out_load) begin
            for (int i = 0; i < MAX_PARITY - 1; i++) begin
                shadow_reg[i] <= shadow_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_byte_reg  <= shadow_reg[0];
            out_index_reg <= cmd.out_index;
            out_last_reg  <= cmd.out_last;
            out_eob_reg   <= eob_reg;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_parity_byte    = out_byte_reg;
    assign m_parity_index   = out_index_reg;
    assign m_last_of_column = out_last_reg;
    assign m_end_of_block   = out_eob_reg;

endmodule
